[rtl/delta_varint_row_decoder_macros.svh]
// ---------------------------------------------------------------------------
// Delta varint row decoder assertion macros
// Shared property shorthands for the checker of the row decoder.
// ---------------------------------------------------------------------------
`ifndef DELTA_VARINT_ROW_DECODER_MACROS_SVH
`define DELTA_VARINT_ROW_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DVRD_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("row decoder check failed in the same cycle");

// The consequent must hold in the cycle after the antecedent.
`define DVRD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("row decoder check failed in the next cycle");

`endif

[rtl/dvrd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delta varint row decoder package
// Phase and status codes and field widths shared by the decoder and its checker.
// ---------------------------------------------------------------------------
package dvrd_pkg;

  localparam int unsigned ROW_W  = 32;
  localparam int unsigned WIDE_W = 64;
  localparam int unsigned SHIFT_W = 6;
  localparam int unsigned STATUS_W = 2;

  // Parser phases; the fourth code behaves as done.
  localparam logic [1:0] PH_DEGREE = 2'd0;
  localparam logic [1:0] PH_ENTRY  = 2'd1;
  localparam logic [1:0] PH_DONE   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_DEST     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd3;

  // Configuration register word index (paddr bit 2).
  localparam logic REG_ROW_COUNT = 1'b0;

  localparam int unsigned OUT_DATA_W = 2 * ROW_W;
  localparam int unsigned OUT_USER_W = STATUS_W + 1;

endpackage

[rtl/delta_varint_row_decoder.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delta varint row decoder
// Decodes the rows section of a delta-coded adjacency store from a byte
// stream of unsigned LEB128 varints into per-row destination items.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Carries
//  --------  ---------  ------------------------------------------------------
//  in_*      slave      one raw byte per item, begin request in tuser
//  out_*     master     row index and destination, status, row/section ends
//  APB       slave      row_count register at byte address 0
//
// Each byte passes an input register, combinational decode logic and an output
// register; a byte that yields a result leaves it in the output register until
// out_tready takes it.
// The decoder sustains one item per cycle while out_tready stays high; the 64-bit
// running-value add and its range compare against row_count set the clock period.
// Reset (rst_n, synchronous) empties both registers and leaves the parser
// done, so bytes are ignored until an item arrives with the begin flag set.
// A stall on out_tready holds the result and, through the decode stage, the
// input register; in_tready drops only when both are occupied.
// ---------------------------------------------------------------------------
module delta_varint_row_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  // Input stream.
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // [7:0] byte_value
  input  logic [0:0]                       in_tuser,   // [0] begin_req
  // Result stream.
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [dvrd_pkg::OUT_DATA_W-1:0]  out_tdata,  // [31:0] row_index,
                                                       // [63:32] destination
  output logic [dvrd_pkg::OUT_USER_W-1:0]  out_tuser,  // [1:0] status,
                                                       // [2] last_of_section
  output logic                             out_tlast,  // last_in_row
  // Configuration port.
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);
  import dvrd_pkg::*;

  // Configuration register.
  logic [ROW_W-1:0] row_count_r;

  // Input register.
  logic       s1_valid_r;
  logic [7:0] s1_byte_r;
  logic       s1_begin_r;

  // Parser state.
  logic [WIDE_W-1:0]  acc_r, acc_nxt;
  logic [SHIFT_W-1:0] shift_r, shift_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [ROW_W-1:0]   row_r, row_nxt;
  logic [WIDE_W-1:0]  rem_r, rem_nxt;
  logic [WIDE_W-1:0]  run_r, run_nxt;

  // Output register.
  logic                out_valid_r;
  logic [ROW_W-1:0]    out_row_r, out_row_nxt;
  logic [ROW_W-1:0]    out_dest_r, out_dest_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_lir_r, out_lir_nxt;
  logic                out_los_r, out_los_nxt;
  logic                emit;

  // Handshake control.
  logic in_fire;
  logic proc_fire;
  logic cfg_write;

  // Decode datapath.
  logic [1:0]         eff_phase;
  logic [WIDE_W-1:0]  eff_acc;
  logic [SHIFT_W-1:0] eff_shift;
  logic [ROW_W-1:0]   eff_row;
  logic [WIDE_W-1:0]  eff_rem;
  logic [WIDE_W-1:0]  eff_run;
  logic               active;
  logic [WIDE_W-1:0]  acc_new;
  logic [SHIFT_W:0]   shift_sum;
  logic [WIDE_W-1:0]  run_sum;
  logic               range_bad;
  logic [ROW_W:0]     next_row;
  logic               row_end;
  logic               rem_last;

  // The decode stage moves only when the output register is free or draining,
  // so a byte that yields no result never overtakes a stalled one.
  assign proc_fire = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || proc_fire;
  assign in_fire   = in_tvalid && in_tready;

  // The APB port never waits; the word address is paddr bit 2.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_ROW_COUNT);
  assign prdata    = (paddr[2] == REG_ROW_COUNT) ? row_count_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= '0;
    end else if (cfg_write) begin
      row_count_r <= pwdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_fire) begin
      s1_valid_r <= 1'b1;
    end else if (proc_fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_byte_r  <= in_tdata;
      s1_begin_r <= in_tuser[0];
    end
  end

  // A begin request clears the parser before its own byte is decoded.
  always_comb begin
    if (s1_begin_r) begin
      eff_phase = (row_count_r == '0) ? PH_DONE : PH_DEGREE;
      eff_acc   = '0;
      eff_shift = '0;
      eff_row   = '0;
      eff_rem   = '0;
      eff_run   = '0;
    end else begin
      eff_phase = phase_r;
      eff_acc   = acc_r;
      eff_shift = shift_r;
      eff_row   = row_r;
      eff_rem   = rem_r;
      eff_run   = run_r;
    end
  end

  assign active    = (eff_phase == PH_DEGREE) || (eff_phase == PH_ENTRY);
  // Bits shifted past bit 63 are dropped.
  assign acc_new   = eff_acc | ({{(WIDE_W-7){1'b0}}, s1_byte_r[6:0]} << eff_shift);
  assign shift_sum = {1'b0, eff_shift} + (SHIFT_W+1)'(7);
  assign run_sum   = eff_run + acc_new;
  assign range_bad = run_sum >= {{(WIDE_W-ROW_W){1'b0}}, row_count_r};
  assign next_row  = {1'b0, eff_row} + (ROW_W+1)'(1);
  assign row_end   = next_row >= {1'b0, row_count_r};
  assign rem_last  = eff_rem == WIDE_W'(1);

  always_comb begin
    acc_nxt        = eff_acc;
    shift_nxt      = eff_shift;
    phase_nxt      = eff_phase;
    row_nxt        = eff_row;
    rem_nxt        = eff_rem;
    run_nxt        = eff_run;
    emit           = 1'b0;
    out_row_nxt    = eff_row;
    out_dest_nxt   = '0;
    out_status_nxt = ST_DEST;
    out_lir_nxt    = 1'b0;
    out_los_nxt    = 1'b0;

    if (active) begin
      if (s1_byte_r[7]) begin
        // Continuation byte: the shift reaching 64 means the varint is too long.
        if (shift_sum[SHIFT_W]) begin
          emit           = 1'b1;
          out_status_nxt = ST_TOO_LONG;
          acc_nxt        = '0;
          shift_nxt      = '0;
          phase_nxt      = PH_DONE;
        end else begin
          acc_nxt   = acc_new;
          shift_nxt = shift_sum[SHIFT_W-1:0];
        end
      end else begin
        acc_nxt   = '0;
        shift_nxt = '0;
        if (eff_phase == PH_DEGREE) begin
          if (acc_new == '0) begin
            // An empty row closes at once.
            emit           = 1'b1;
            out_status_nxt = ST_EMPTY;
            out_lir_nxt    = 1'b1;
            out_los_nxt    = row_end;
            run_nxt        = '0;
            rem_nxt        = '0;
            row_nxt        = next_row[ROW_W-1:0];
            phase_nxt      = row_end ? PH_DONE : PH_DEGREE;
          end else begin
            rem_nxt   = acc_new;
            run_nxt   = '0;
            phase_nxt = PH_ENTRY;
          end
        end else begin
          run_nxt = run_sum;
          emit    = 1'b1;
          if (range_bad) begin
            out_status_nxt = ST_RANGE;
            phase_nxt      = PH_DONE;
          end else begin
            out_dest_nxt = run_sum[ROW_W-1:0];
            rem_nxt      = eff_rem - WIDE_W'(1);
            if (rem_last) begin
              // Final entry of the row; advance to the next one.
              out_lir_nxt = 1'b1;
              out_los_nxt = row_end;
              run_nxt     = '0;
              rem_nxt     = '0;
              row_nxt     = next_row[ROW_W-1:0];
              phase_nxt   = row_end ? PH_DONE : PH_DEGREE;
            end
          end
        end
      end
    end
  end

  // Parser state update.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r   <= '0;
      shift_r <= '0;
      phase_r <= PH_DONE;
      row_r   <= '0;
      rem_r   <= '0;
      run_r   <= '0;
    end else if (proc_fire) begin
      acc_r   <= acc_nxt;
      shift_r <= shift_nxt;
      phase_r <= phase_nxt;
      row_r   <= row_nxt;
      rem_r   <= rem_nxt;
      run_r   <= run_nxt;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (proc_fire) begin
      out_valid_r <= emit;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire && emit) begin
      out_row_r    <= out_row_nxt;
      out_dest_r   <= out_dest_nxt;
      out_status_r <= out_status_nxt;
      out_lir_r    <= out_lir_nxt;
      out_los_r    <= out_los_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_dest_r, out_row_r};
  assign out_tuser  = {out_los_r, out_status_r};
  assign out_tlast  = out_lir_r;

endmodule

[rtl/dvrd_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delta varint row decoder checker
// Port-level checks on the result stream, bound into the row decoder.
// ---------------------------------------------------------------------------
`include "delta_varint_row_decoder_macros.svh"

module dvrd_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [dvrd_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [dvrd_pkg::OUT_USER_W-1:0]  out_tuser,
  input logic                             out_tlast
);
  import dvrd_pkg::*;

  logic [STATUS_W-1:0]                    status;
  logic                                   is_error;
  logic                                   stalled;
  logic                                   los_flag;
  logic [ROW_W-1:0]                       dest;
  logic [OUT_DATA_W+OUT_USER_W:0]         out_bundle;

  assign status     = out_tuser[STATUS_W-1:0];
  assign is_error   = (status == ST_TOO_LONG) || (status == ST_RANGE);
  assign stalled    = out_tvalid && !out_tready;
  assign los_flag   = out_tuser[STATUS_W];
  assign dest       = out_tdata[OUT_DATA_W-1:ROW_W];
  assign out_bundle = {out_tlast, out_tuser, out_tdata};

  // A stalled result holds.
  `DVRD_ASSERT_NEXT(a_stall_hold, clk, rst_n, stalled, out_tvalid && $stable(out_bundle))

  // Errors never close a row or the section.
  `DVRD_ASSERT_SAME(a_error_no_last, clk, rst_n, out_tvalid && is_error, !out_tlast && !los_flag)

  // The end of the section is always the end of a row.
  `DVRD_ASSERT_SAME(a_section_end_row, clk, rst_n, out_tvalid && los_flag, out_tlast)

  // Only a destination result carries a nonzero destination.
  `DVRD_ASSERT_SAME(a_dest_zero, clk, rst_n, out_tvalid && (status != ST_DEST), dest == '0)

endmodule

bind delta_varint_row_decoder dvrd_checker u_dvrd_checker (.*);

[verif/delta_varint_row_decoder_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Delta varint row decoder testbench
// Drives LEB128-coded row sections byte by byte and checks every result item
// against a cycle-free predictor of the parser or a typed expectation, under
// random source gaps, random sink stalls and a series of row_count settings.
// ---------------------------------------------------------------------------
module delta_varint_row_decoder_tb;
  import dvrd_pkg::*;

  // Two register stages sit between input and output. The idle drain lets a
  // byte that produces nothing clear the pipeline.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_BYTES = 1200;
  localparam int DIR_ROWS = 23;
  localparam logic [2:0] ROW_COUNT_ADDR = {REG_ROW_COUNT, 2'b00};

  // One decoded result, holding the fields of the result stream.
  typedef struct packed {
    logic [31:0] row;
    logic [31:0] dest;
    logic [1:0]  status;
    logic        lir;
    logic        los;
  } row_result_t;

  localparam row_result_t NO_RES = '{default: '0};

  // How a directed row is checked: by the predictor, as producing nothing,
  // or against the expectation typed into the table.
  typedef enum logic [1:0] {CHK_MODEL, CHK_NONE, CHK_TABLE} chk_kind_t;

  typedef struct {
    logic [7:0]  b;
    logic        beg;
    chk_kind_t   kind;
    row_result_t res;
  } stim_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;   // [7:0] byte_value
  logic [0:0]            in_tuser;   // [0] begin_req
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;  // [31:0] row_index, [63:32] destination
  logic [OUT_USER_W-1:0] out_tuser;  // [1:0] status, [2] last_of_section
  logic                  out_tlast;  // last_in_row
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [2:0]            paddr;
  logic [31:0]           pwdata;
  logic [31:0]           prdata;
  logic                  pready;

  delta_varint_row_decoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // Expected results in arrival order, and run bookkeeping.
  row_result_t pending_results[$];
  int          fails;
  int          bytes_decoded;
  int          settings_used;
  int          status_seen[4];
  bit          no_idle;
  stim_row_t   dir_tab[DIR_ROWS];

  // Parser state as the block should hold it, plus its view of row_count.
  logic [63:0] m_acc;
  logic [6:0]  m_shift;
  logic [1:0]  m_phase;
  logic [31:0] m_row;
  logic [63:0] m_left;
  logic [63:0] m_run;
  logic [31:0] m_rows;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // A separate watchdog: the slowest legal run is far below this.
  initial begin
    #(5_000_000);
    $display("delta_varint_row_decoder verification failed");
    $finish;
  end

  // Closes the current row. Returns 1 when the next row index is not below
  // the present row_count, which ends the section.
  function automatic logic close_row();
    logic [32:0] nxt;
    nxt = {1'b0, m_row} + 33'd1;
    m_run = '0;
    m_left = '0;
    m_row = nxt[31:0];
    if (nxt >= {1'b0, m_rows}) begin
      m_phase = PH_DONE;
      return 1'b1;
    end
    m_phase = PH_DEGREE;
    return 1'b0;
  endfunction

  // Predicts what one accepted byte does to the parser and what it emits.
  task automatic decode_byte(input logic [7:0] b, input logic beg, output bit got,
                             output row_result_t r);
    logic [63:0] value;
    got = 1'b0;
    r = NO_RES;
    if (beg) begin
      m_acc = '0;
      m_shift = '0;
      m_row = '0;
      m_left = '0;
      m_run = '0;
      m_phase = (m_rows == 32'd0) ? PH_DONE : PH_DEGREE;
    end
    // Done, halted after an error, or the unused phase code: byte is dropped.
    if (m_phase != PH_DEGREE && m_phase != PH_ENTRY) return;
    bytes_decoded++;
    m_acc |= 64'(b[6:0]) << m_shift[5:0];
    if (b[7]) begin
      m_shift += 7'd7;
      if (m_shift >= 7'd64) begin
        got = 1'b1;
        r = '{m_row, 32'd0, ST_TOO_LONG, 1'b0, 1'b0};
        m_acc = '0;
        m_shift = '0;
        m_phase = PH_DONE;
      end
      return;
    end
    value = m_acc;
    m_acc = '0;
    m_shift = '0;
    r.row = m_row;
    if (m_phase == PH_DEGREE) begin
      if (value == 64'd0) begin
        got = 1'b1;
        r.status = ST_EMPTY;
        r.lir = 1'b1;
        r.los = close_row();
      end else begin
        m_left = value;
        m_run = '0;
        m_phase = PH_ENTRY;
      end
      return;
    end
    // Entry phase: the delta wraps at 64 bits before the range check.
    m_run += value;
    got = 1'b1;
    if (m_run >= {32'd0, m_rows}) begin
      r.status = ST_RANGE;
      m_phase = PH_DONE;
      return;
    end
    r.dest = m_run[31:0];
    r.status = ST_DEST;
    m_left -= 64'd1;
    if (m_left == 64'd0) begin
      r.lir = 1'b1;
      r.los = close_row();
    end
  endtask

  // Offers one byte after a random gap and waits for it to be taken. The
  // expectation is queued at the edge that accepts the byte.
  task automatic push_byte(input logic [7:0] b, input logic beg, input chk_kind_t kind,
                           input row_result_t typed);
    int          gap;
    bit          got;
    row_result_t r;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= beg;
    do @(posedge clk); while (!in_tready);
    decode_byte(b, beg, got, r);
    if (kind == CHK_TABLE) begin
      got = 1'b1;
      r = typed;
    end else if (kind == CHK_NONE) begin
      got = 1'b0;
    end
    if (got) pending_results.insert(pending_results.size(), r);
  endtask

  // Encodes a value as LEB128, sometimes padded with empty continuation groups
  // up to the ten-byte limit. On a tenth byte the upper data bits are dropped
  // by the block, so they are filled with junk half of the time.
  task automatic send_varint(input logic [63:0] v, input logic beg);
    int         len;
    int         i;
    logic [7:0] b;
    len = 1;
    while (len < 10 && (v >> (7 * len)) != 64'd0) len++;
    if ($urandom_range(0, 5) == 0) len = $urandom_range(len, 10);
    for (i = 0; i < len; i++) begin
      b = {i < len - 1, 7'((v >> (7 * i)) & 64'h7f)};
      if (i == 9 && $urandom_range(0, 1) == 1) b[6:1] = 6'($urandom);
      push_byte(b, beg && i == 0, CHK_MODEL, NO_RES);
    end
  endtask

  // Sends a run of varints shaped to follow the parser: degrees where it
  // expects a degree, deltas that land on chosen destinations otherwise, with
  // a sprinkling of restarts, stray bytes, overlong varints and bad targets.
  task automatic drive_section(input logic with_begin, input int n_vars);
    logic        beg;
    logic [63:0] v;
    logic [63:0] target;
    logic [63:0] rc;
    int          k;
    int          i;
    int          pick;
    beg = with_begin;
    for (k = 0; k < n_vars; k++) begin
      if (!beg && $urandom_range(0, 49) == 0) beg = 1'b1;
      if (!beg && m_phase != PH_DEGREE && m_phase != PH_ENTRY) break;
      rc = {32'd0, m_rows};
      pick = $urandom_range(0, 59);
      if (pick == 0) begin
        // Ten continuation bytes push the shift past 64.
        for (i = 0; i < 10; i++)
          push_byte(8'h80 | 8'($urandom), beg && i == 0, CHK_MODEL, NO_RES);
      end else if (pick == 1) begin
        push_byte(8'($urandom), beg, CHK_MODEL, NO_RES);
      end else if (beg || m_phase == PH_DEGREE) begin
        case ($urandom_range(0, 9))
          0, 1:    v = 64'd0;
          2:       v = {$urandom, $urandom};
          default: v = 64'($urandom_range(1, 4));
        endcase
        send_varint(v, beg);
      end else begin
        pick = $urandom_range(0, 23);
        if (pick == 0)
          target = rc + 64'($urandom_range(0, 3));
        else if (pick == 1)
          target = {1'b1, 63'({$urandom, $urandom})};
        else if (rc == 64'd0)
          target = 64'd0;
        else if (pick < 6)
          target = rc - 64'd1;
        else
          target = {$urandom, $urandom} % rc;
        // Going backwards from the running value relies on the 64-bit wrap.
        v = target - m_run;
        send_varint(v, beg);
      end
      beg = 1'b0;
    end
    // Now and then a byte that arrives after the section or after an error.
    if (m_phase != PH_DEGREE && m_phase != PH_ENTRY && $urandom_range(0, 2) == 0)
      push_byte(8'($urandom), 1'b0, CHK_MODEL, NO_RES);
  endtask

  // Stops the source and waits until every expected item is out and any byte
  // that produces nothing has cleared the pipeline.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      fails++;
    end
  endtask

  // Writes row_count over the configuration port, then reads it back.
  task automatic write_row_count(input logic [31:0] v);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ROW_COUNT_ADDR;
    pwdata  <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    m_rows = v;
    settings_used++;
    @(posedge clk);
    psel   <= 1'b1;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    check_field("row_count readback", {32'd0, v}, {32'd0, prdata});
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result sink: a fresh random stall before each item, or none at all while
  // the current phase runs without idling.
  initial begin : result_sink
    int stall;
    out_tready = 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Every accepted result is matched against the oldest expectation.
  always @(posedge clk) begin : result_monitor
    row_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      status_seen[out_tuser[1:0]]++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: row 0x%0h status %0d", out_tdata[31:0], out_tuser[1:0]);
        fails++;
      end else begin
        want = pending_results.pop_front();
        check_field("row_index", 64'(want.row), 64'(out_tdata[31:0]));
        check_field("destination", 64'(want.dest), 64'(out_tdata[63:32]));
        check_field("status", 64'(want.status), 64'(out_tuser[1:0]));
        check_field("last_in_row", 64'(want.lir), 64'(out_tlast));
        check_field("last_of_section", 64'(want.los), 64'(out_tuser[2]));
      end
    end
  end

  initial begin : stimulus
    int          n;
    int          random_start;
    logic [31:0] rc;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    fails         = 0;
    bytes_decoded = 0;
    settings_used = 0;
    no_idle       = 1'b0;
    m_acc   = '0;
    m_shift = '0;
    m_phase = PH_DONE;
    m_row   = '0;
    m_left  = '0;
    m_run   = '0;
    m_rows  = '0;

    // Directed walk with row_count = 4: a byte before any begin, a section of
    // four rows (two deltas, an empty row, a two-byte delta, an empty last
    // row), a byte after the section, an overlong varint, and an
    // out-of-range destination followed by a byte while halted.
    dir_tab = '{
      '{8'h05, 1'b0, CHK_NONE,  NO_RES},
      '{8'h02, 1'b1, CHK_NONE,  NO_RES},
      '{8'h01, 1'b0, CHK_MODEL, NO_RES},
      '{8'h02, 1'b0, CHK_MODEL, NO_RES},
      '{8'h00, 1'b0, CHK_TABLE, '{32'd1, 32'd0, ST_EMPTY, 1'b1, 1'b0}},
      '{8'h01, 1'b0, CHK_NONE,  NO_RES},
      '{8'h82, 1'b0, CHK_NONE,  NO_RES},
      '{8'h00, 1'b0, CHK_MODEL, NO_RES},
      '{8'h00, 1'b0, CHK_TABLE, '{32'd3, 32'd0, ST_EMPTY, 1'b1, 1'b1}},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b1, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_NONE,  NO_RES},
      '{8'hff, 1'b0, CHK_TABLE, '{32'd0, 32'd0, ST_TOO_LONG, 1'b0, 1'b0}},
      '{8'h01, 1'b1, CHK_NONE,  NO_RES},
      '{8'h7f, 1'b0, CHK_TABLE, '{32'd0, 32'd0, ST_RANGE, 1'b0, 1'b0}},
      '{8'h00, 1'b0, CHK_NONE,  NO_RES}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_row_count(32'd4);
    for (n = 0; n < DIR_ROWS; n++)
      push_byte(dir_tab[n].b, dir_tab[n].beg, dir_tab[n].kind, dir_tab[n].res);

    // Random phases. Each one may pick a new row_count, including zero, one
    // and the full 32-bit value, and usually restarts the section; otherwise
    // the parser carries on from where the last phase left it, so some rows
    // see their bound change halfway through.
    random_start = bytes_decoded;
    while (bytes_decoded - random_start < RANDOM_BYTES) begin
      settle();
      if ($urandom_range(0, 2) != 0) begin
        case ($urandom_range(0, 9))
          0:       rc = 32'd0;
          1:       rc = 32'd1;
          2:       rc = 32'hffff_ffff;
          3:       rc = $urandom;
          default: rc = 32'($urandom_range(2, 24));
        endcase
        write_row_count(rc);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      drive_section($urandom_range(0, 4) != 0, $urandom_range(4, 40));
    end

    settle();
    $display("Decoded %0d bytes under %0d row_count settings.", bytes_decoded,
             settings_used);
    $display("Results: %0d destinations, %0d empty rows, %0d overlong, %0d out of range.",
             status_seen[ST_DEST], status_seen[ST_EMPTY], status_seen[ST_TOO_LONG],
             status_seen[ST_RANGE]);
    if (fails == 0) begin
      $display("delta_varint_row_decoder verification clean");
    end else begin
      $display("delta_varint_row_decoder verification failed");
    end
    $finish;
  end

endmodule

[delta_varint_row_decoder.f]
+incdir+rtl
rtl/dvrd_pkg.sv
rtl/delta_varint_row_decoder.sv
rtl/dvrd_checker.sv
verif/delta_varint_row_decoder_tb.sv
